// ===== src/ltvd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltvd_pkg - shared types and constants for the TLV deframer
// Header layout, result item layout and stream widths.
// ----------------------------------------------------------------------------
package ltvd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int HDR_BYTES   = 8;
    localparam int POS_W       = $clog2(HDR_BYTES);
    localparam int LANE_W      = 2;

    // header byte positions
    localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HDR_BYTES - 1);

    // output stream packing
    localparam int OUT_DATA_W  = BYTE_W + WORD_W;   // 40, already whole bytes
    localparam int OUT_USER_W  = 2;

    typedef struct packed {
        logic               empty_message;
        logic               last_of_message;
        logic               first_of_message;
        logic [WORD_W-1:0]  message_type;
        logic [BYTE_W-1:0]  payload_byte;
    } t_result;

endpackage
`default_nettype wire

// ===== src/ltvd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltvd_core - input register and header/payload tracking
// Holds one input byte, gathers the 8-byte header and tags payload bytes.
// ----------------------------------------------------------------------------
module ltvd_core
    import ltvd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_res_valid,
    output t_result                o_res
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic [POS_W-1:0]  r_pos,        n_pos;
    logic [WORD_W-1:0] r_remaining,  n_remaining;   // gathered length, then countdown
    logic [WORD_W-1:0] r_type,       n_type;
    logic              r_in_payload, n_in_payload;
    logic              r_first,      n_first;

    logic              advance;
    logic [WORD_W-1:0] lane_word;
    logic [WORD_W-1:0] len_base;
    logic [WORD_W-1:0] type_base;
    logic              last_byte;

    assign advance    = r_in_valid & i_out_ready;
    assign o_in_ready = ~r_in_valid | i_out_ready;

    // byte placed into its little-endian lane
    assign lane_word  = WORD_W'(r_in_byte) << {r_pos[LANE_W-1:0], 3'b000};
    assign len_base   = (r_pos == POS_FIRST) ? '0 : r_remaining;
    assign type_base  = (r_pos == POS_FIRST) ? '0 : r_type;
    assign last_byte  = (r_remaining[WORD_W-1:1] == '0);

    always_comb begin
        n_pos        = r_pos;
        n_remaining  = r_remaining;
        n_type       = r_type;
        n_in_payload = r_in_payload;
        n_first      = r_first;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (advance) begin
            if (r_in_payload) begin
                o_res_valid            = 1'b1;
                o_res.payload_byte     = r_in_byte;
                o_res.message_type     = r_type;
                o_res.first_of_message = r_first;
                o_res.last_of_message  = last_byte;
                n_first                = 1'b0;
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - WORD_W'(1);
                end
                if (last_byte) begin
                    n_in_payload = 1'b0;
                    n_pos        = POS_FIRST;
                end
            end else begin
                if (!r_pos[POS_W-1]) begin
                    n_remaining = len_base | lane_word;
                    // type restarts on the first header byte
                    n_type      = type_base;
                end else begin
                    n_type = type_base | lane_word;
                end
                if (r_pos == POS_HDR_LAST) begin
                    n_pos = POS_FIRST;
                    if (r_remaining == '0) begin
                        // zero-length message: single empty result
                        o_res_valid            = 1'b1;
                        o_res.message_type     = n_type;
                        o_res.first_of_message = 1'b1;
                        o_res.last_of_message  = 1'b1;
                        o_res.empty_message    = 1'b1;
                    end else begin
                        n_in_payload = 1'b1;
                        n_first      = 1'b1;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pos        <= POS_FIRST;
            r_remaining  <= '0;
            r_type       <= '0;
            r_in_payload <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_pos        <= n_pos;
            r_remaining  <= n_remaining;
            r_type       <= n_type;
            r_in_payload <= n_in_payload;
            r_first      <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule
`default_nettype wire

// ===== src/ltvd_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltvd_skid - result register with skid stage
// Two-entry output buffer; ready upstream is a register output.
// ----------------------------------------------------------------------------
module ltvd_skid
    import ltvd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    drain;

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign take    = i_valid & ~r_skid_valid;
    assign drain   = r_out_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (!r_out_valid || drain) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (drain) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (!r_out_valid || drain) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end else if (drain && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
`default_nettype wire

// ===== src/length_type_value_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// length_type_value_deframer_unit - length-prefixed type/value deframer
// Splits a byte stream into messages: 8-byte header (LE length, LE type)
// followed by payload; one output transaction per payload byte or empty message.
// ----------------------------------------------------------------------------
//  channel     dir  width            contents
//  s_axis      in   tdata 8          raw stream byte
//  m_axis      out  tdata 40, tlast, payload byte, type, first/empty in tuser
//                   tuser 2
//
//  One byte is taken every clock while the output side keeps up; header
//  bytes produce no output transaction, payload bytes one each, and the
//  last header byte of an empty message one. Input to output passes the
//  input register, then the result register of the skid stage.
//  Reset (synchronous, active low) clears the header position, the length
//  and type accumulators and all valid flags; the block then expects a header.
//  A stall on m_axis fills the skid stage; s_axis tready drops only once
//  it holds a waiting result, and is driven from registers alone.
// ----------------------------------------------------------------------------
module length_type_value_deframer_unit
    import ltvd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave side
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] in_byte
    // master side
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // [7:0] payload_byte,
                                                         // [39:8] message_type
    output logic                       o_m_axis_tlast,   // last_of_message
    output logic [OUT_USER_W-1:0]      o_m_axis_tuser    // [0] first_of_message,
                                                         // [1] empty_message
);

    logic    res_valid;
    t_result res;
    logic    skid_ready;
    t_result out_res;

    // header gathering and payload tagging
    ltvd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_byte   (i_s_axis_tdata),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (skid_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register plus skid entry
    ltvd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (skid_ready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {out_res.message_type, out_res.payload_byte};
    assign o_m_axis_tlast = out_res.last_of_message;
    assign o_m_axis_tuser = {out_res.empty_message, out_res.first_of_message};

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb - self-checking bench for length_type_value_deframer_unit
// Feeds a byte stream of framed messages (directed corner cases, then random
// frames including one long payload) with random idling on both
// streams. Every output transaction is checked against an in-bench model of
// the deframer.
// ----------------------------------------------------------------------------
module tb;
    import ltvd_pkg::*;

    localparam int          RANDOM_ITEMS   = 2000;
    localparam int          TAIL_ITEMS     = 200;     // no idling for the last bytes
    localparam int          HOLDOFF_AT     = 150;     // results seen before long stall
    localparam int          HOLDOFF_CYCLES = 64;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [31:0] LONG_LEN       = 32'h0000_0203;
    localparam int          USER_FIRST     = 0;
    localparam int          USER_EMPTY     = 1;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                drain_first;   // wait for all results before sending
    } t_stream_byte;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  s_valid    = 1'b0;
    logic [BYTE_W-1:0]     s_data     = '0;
    logic                  m_ready    = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_last;
    logic [OUT_USER_W-1:0] m_user;

    t_stream_byte          pending_bytes[$];
    t_result               expected_results[$];
    int                    errors = 0;

    // deframer model state
    logic [3:0]            hdr_pos   = '0;
    logic [WORD_W-1:0]     len_acc   = '0;
    logic [WORD_W-1:0]     type_acc  = '0;
    logic [WORD_W-1:0]     remaining = '0;
    logic                  in_body   = 1'b0;
    logic                  first_due = 1'b0;

    // driver / sink bookkeeping
    int                    src_gap    = 0;
    int                    sink_gap   = 0;
    int                    hold_left  = 0;
    bit                    hold_done  = 1'b0;
    int                    rx_count   = 0;
    int                    idle_count = 0;

    length_type_value_deframer_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit in_tail();
        return pending_bytes.size() < TAIL_ITEMS;
    endfunction

    // Advance the model by one accepted byte; payload bytes and empty
    // headers queue one expected result.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        t_result          r;
        logic [POS_W-1:0] pos;
        r = '0;
        if (in_body) begin
            r.payload_byte     = b;
            r.message_type     = type_acc;
            r.first_of_message = first_due;
            r.last_of_message  = (remaining <= 1);
            r.empty_message    = 1'b0;
            first_due = 1'b0;
            if (remaining != 0)
                remaining = remaining - 1;
            if (remaining == 0) begin
                in_body = 1'b0;
                hdr_pos = '0;
            end
            expected_results = {expected_results, r};
        end else begin
            pos = hdr_pos[POS_W-1:0];
            if (pos == POS_FIRST) begin
                len_acc  = '0;
                type_acc = '0;
            end
            // low half of the header is the length, high half the type
            if (!pos[POS_W-1])
                len_acc  = len_acc  | (WORD_W'(b) << (BYTE_W * pos[LANE_W-1:0]));
            else
                type_acc = type_acc | (WORD_W'(b) << (BYTE_W * pos[LANE_W-1:0]));
            if (pos == POS_HDR_LAST) begin
                hdr_pos = '0;
                if (len_acc == 0) begin
                    r.message_type     = type_acc;
                    r.first_of_message = 1'b1;
                    r.last_of_message  = 1'b1;
                    r.empty_message    = 1'b1;
                    expected_results = {expected_results, r};
                end else begin
                    remaining = len_acc;
                    in_body   = 1'b1;
                    first_due = 1'b1;
                end
            end else begin
                hdr_pos = 4'(pos) + 4'd1;
            end
        end
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b, input bit drain);
        t_stream_byte item;
        item.data        = b;
        item.drain_first = drain;
        pending_bytes = {pending_bytes, item};
    endfunction

    function automatic void add_header(input logic [WORD_W-1:0] len,
                                       input logic [WORD_W-1:0] mtype, input bit drain);
        for (int i = 0; i < 4; i++)
            push_byte(len[BYTE_W*i +: BYTE_W], drain && (i == 0));
        for (int i = 0; i < 4; i++)
            push_byte(mtype[BYTE_W*i +: BYTE_W], 1'b0);
    endfunction

    function automatic void add_message(input logic [WORD_W-1:0] len,
                                        input logic [WORD_W-1:0] mtype, input bit drain);
        add_header(len, mtype, drain);
        for (int unsigned i = 0; i < len; i++)
            push_byte(BYTE_W'($urandom), 1'b0);
    endfunction

    function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Stimulus and end of run
    initial begin
        int unsigned      pick;
        int unsigned      len;
        logic [WORD_W-1:0] mtype;
        int               count;
        int               msgs;

        // empty message with an all-ones type
        add_header(32'd0, 32'hFFFF_FFFF, 1'b0);
        // two-byte payload, extreme byte values, zero type
        add_header(32'd2, 32'h0000_0000, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // single byte payload: first and last together
        add_header(32'd1, 32'h8000_0001, 1'b0);
        push_byte(8'h7F, 1'b0);

        count = 0;
        msgs  = 0;
        while (count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = 0;
            else if (pick < 85)
                len = $urandom_range(1, 16);
            else if (pick < 97)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(256, 300);   // second length byte set
            pick = $urandom_range(0, 7);
            if (pick == 0)
                mtype = '0;
            else if (pick == 1)
                mtype = '1;
            else
                mtype = $urandom;
            add_message(len, mtype, (msgs % 37) == 5);
            // one long payload, low and second length bytes set
            if (msgs == 60) begin
                add_message(LONG_LEN, $urandom, 1'b0);
                count += HDR_BYTES + int'(LONG_LEN);
            end
            count += HDR_BYTES + len;
            msgs++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Byte stream driver
    always @(posedge clk) begin
        t_stream_byte nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                deframe_byte(s_data);

            if (s_valid && !s_ready) begin
                // transaction held until taken
            end else if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_bytes[0].drain_first && expected_results.size() != 0) begin
                s_valid <= 1'b0;
            end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
                src_gap <= $urandom_range(0, 2);
                s_valid <= 1'b0;
            end else begin
                nxt = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_data  <= nxt.data;
            end
        end
    end

    // Result sink: random back-pressure plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready)
                rx_count <= rx_count + 1;

            if (!hold_done && rx_count == HOLDOFF_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLDOFF_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h last %b user %b",
                         $time, m_data, m_last, m_user);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("payload_byte", WORD_W'(want.payload_byte),
                              WORD_W'(m_data[BYTE_W-1:0]));
                compare_field("message_type", want.message_type, m_data[BYTE_W +: WORD_W]);
                compare_field("first_of_message", WORD_W'(want.first_of_message),
                              WORD_W'(m_user[USER_FIRST]));
                compare_field("last_of_message", WORD_W'(want.last_of_message),
                              WORD_W'(m_last));
                compare_field("empty_message", WORD_W'(want.empty_message),
                              WORD_W'(m_user[USER_EMPTY]));
            end
        end
    end

    // Watchdog: cycles with no transaction on either stream
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/ltvd_pkg.sv
src/ltvd_core.sv
src/ltvd_skid.sv
src/length_type_value_deframer_unit.sv
dv/tb.sv
